@@ rtl/dmt_pkg.sv @@
// Shared types, constants and helper functions of the depth map triangulator.
`default_nettype none
package dmt_pkg;

  localparam int Z_W = 16;
  localparam int COL_W = 13;
  localparam int ROW_W = 16;
  localparam int DESC_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_INV_FOCAL_X  = 3'd2;
  localparam logic [2:0] REG_INV_FOCAL_Y  = 3'd3;
  localparam logic [2:0] REG_CENTER_X     = 3'd4;
  localparam logic [2:0] REG_CENTER_Y     = 3'd5;
  localparam logic [2:0] REG_U_STEP       = 3'd6;
  localparam logic [2:0] REG_V_STEP       = 3'd7;

  localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd480;
  localparam logic [23:0] RST_INV_FOCAL_X  = 24'd31957;
  localparam logic [23:0] RST_INV_FOCAL_Y  = 24'd31957;
  localparam logic [14:0] RST_CENTER_X     = 15'd5120;
  localparam logic [19:0] RST_CENTER_Y     = 20'd3840;
  localparam logic [23:0] RST_U_STEP       = 24'd26214;
  localparam logic [23:0] RST_V_STEP       = 24'd34953;

  typedef struct packed {
    logic [11:0] image_width;
    logic [15:0] image_height;
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
    logic [14:0] center_x;
    logic [19:0] center_y;
    logic [23:0] u_step;
    logic [23:0] v_step;
  } cfg_t;

  typedef struct packed {
    logic [15:0] depth_sample;
    logic        start_of_frame;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        pos_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic               last_vertex;
  } out_item_t;

  typedef struct packed {
    logic [Z_W-1:0]   d0;
    logic [Z_W-1:0]   d1;
    logic [Z_W-1:0]   d2;
    logic [Z_W-1:0]   d3;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [3:0]       sets;
  } desc_t;

  function automatic logic [1:0] tri_corner(input logic [1:0] set, input logic [1:0] pos);
    logic [1:0] k;
    k = 2'd0;
    unique case ({set, pos})
      4'b0000: k = 2'd3;
      4'b0001: k = 2'd1;
      4'b0010: k = 2'd2;
      4'b0100: k = 2'd0;
      4'b0101: k = 2'd2;
      4'b0110: k = 2'd3;
      4'b1000: k = 2'd3;
      4'b1001: k = 2'd1;
      4'b1010: k = 2'd0;
      4'b1100: k = 2'd0;
      4'b1101: k = 2'd2;
      4'b1110: k = 2'd1;
      default: k = 2'd0;
    endcase
    return k;
  endfunction

  function automatic logic edge_ok(input logic [Z_W-1:0] a, input logic [Z_W-1:0] b);
    logic [Z_W-1:0] m;
    logic [Z_W-1:0] d;
    logic [Z_W+4:0] d20;
    m = (a > b) ? a : b;
    d = (a > b) ? (a - b) : (b - a);
    d20 = {1'b0, d, 4'b0000} + {3'b000, d, 2'b00};
    return d20 < {5'b00000, m};
  endfunction

endpackage
`default_nettype wire

@@ rtl/depth_map_triangulator_top.sv @@
// Top level of the depth map triangulator.
// Depth pixels arrive in raster order on the input queue port: a transfer
// happens when in_push is high and in_full is low. start_of_frame marks the
// first pixel of a frame. Each pixel that closes a 2x2 quad yields zero, three
// or six vertices on the result queue port; the oldest vertex is shown while
// out_empty is low and leaves on out_pop. last_vertex flags the final vertex
// of a pixel. Configuration registers are written through cfg_we, cfg_index
// and cfg_wdata while the block is idle.
// The front end takes one pixel at a time: it reads the line store, then
// classifies the quad and writes the line store, with a further write on the
// last column of a row; it holds in classify while the descriptor queue is
// full. The back end loads a descriptor, then issues one vertex per cycle,
// while fewer than OUT_DEPTH vertices are in flight or queued, into a 4-stage
// projection pipeline. A short descriptor queue sits between them.
// After reset the line store is cleared entry by entry, during which
// in_full stays high. When the receiver stalls, up to 8 vertices collect in
// the output queue, then the back end and then the front end hold.
`default_nettype none
module depth_map_triangulator_top
  import dmt_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int DEPTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_item_t    in_data,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam int DESC_W = $bits(desc_t);
  localparam int OUT_W  = $bits(out_item_t);

  cfg_t             cfg_r;
  logic             fq_push;
  desc_t            fq_wdata;
  logic             fq_full;
  logic             fq_pop;
  logic             fq_empty;
  logic [DESC_W-1:0] fq_rdata;
  logic             o_push;
  out_item_t        o_data;
  logic             o_full;
  logic             o_pop;
  logic [OUT_W-1:0] o_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= RST_IMAGE_WIDTH;
      cfg_r.image_height <= RST_IMAGE_HEIGHT;
      cfg_r.inv_focal_x  <= RST_INV_FOCAL_X;
      cfg_r.inv_focal_y  <= RST_INV_FOCAL_Y;
      cfg_r.center_x     <= RST_CENTER_X;
      cfg_r.center_y     <= RST_CENTER_Y;
      cfg_r.u_step       <= RST_U_STEP;
      cfg_r.v_step       <= RST_V_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_wdata[11:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_wdata[15:0];
        REG_INV_FOCAL_X:  cfg_r.inv_focal_x  <= cfg_wdata;
        REG_INV_FOCAL_Y:  cfg_r.inv_focal_y  <= cfg_wdata;
        REG_CENTER_X:     cfg_r.center_x     <= cfg_wdata[14:0];
        REG_CENTER_Y:     cfg_r.center_y     <= cfg_wdata[19:0];
        REG_U_STEP:       cfg_r.u_step       <= cfg_wdata;
        REG_V_STEP:       cfg_r.v_step       <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  dmt_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (fq_push),
    .q_data  (fq_wdata),
    .q_full  (fq_full)
  );

  dmt_queue #(
    .WIDTH (DESC_W),
    .DEPTH (DESC_DEPTH)
  ) u_desc_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .empty (fq_empty),
    .rdata (fq_rdata)
  );

  dmt_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (fq_empty),
    .q_data  (desc_t'(fq_rdata)),
    .q_pop   (fq_pop),
    .o_push  (o_push),
    .o_data  (o_data),
    .o_pop   (o_pop)
  );

  assign o_pop = out_pop & ~out_empty;

  dmt_queue #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .wdata (o_data),
    .full  (o_full),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (o_rdata)
  );

  assign out_data = out_item_t'(o_rdata);

endmodule
`default_nettype wire

@@ rtl/dmt_queue.sv @@
// Small first-in first-out queue built from registers.
`default_nettype none
module dmt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW:0]      count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

@@ rtl/dmt_front.sv @@
// Pixel front end: raster counters, line store and quad classification.
`default_nettype none
module dmt_front
  import dmt_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int DEPTH_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_data,
  output logic     q_push,
  output desc_t    q_data,
  input  logic     q_full
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SB = (DEPTH_BITS < Z_W) ? DEPTH_BITS : Z_W;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_CLS  = 2'd2;
  localparam logic [1:0] ST_WR2  = 2'd3;

  logic [1:0]    state_r;
  logic [1:0]    state_nxt;
  logic [CW-1:0] clr_addr_r;
  logic [CW-1:0] col_r;
  logic [15:0]   row_r;
  logic [SB-1:0] left_r;
  logic [SB-1:0] cur_r;
  logic [CW-1:0] pcol_r;
  logic [15:0]   prow_r;
  logic          plast_r;
  logic [SB-1:0] rd0_r;
  logic [SB-1:0] rd1_r;
  logic [SB-1:0] mem [MAX_WIDTH];

  logic [31:0]   weff32;
  logic [CW:0]   weff;
  logic [15:0]   heff;
  logic          accept;
  logic [CW-1:0] c_s;
  logic [15:0]   r_s;
  logic [CW:0]   c_n;
  logic [15:0]   r_n;
  logic [CW-1:0] ra0;

  logic          mem_we;
  logic [CW-1:0] mem_wa;
  logic [SB-1:0] mem_wd;

  logic [Z_W-1:0] d0, d1, d2, d3;
  logic [Z_W-1:0] ad03, ad12;
  logic [3:0]     v;
  logic [2:0]     nv;
  logic [3:0]     sel;
  logic [3:0]     ok;
  logic [3:0]     sets;
  logic           e01, e02, e03, e12, e13, e23;
  logic           advance;

  always_comb begin
    weff32 = {20'd0, cfg.image_width};
    if (weff32 < 32'd2) begin
      weff32 = 32'd2;
    end else if (weff32 > 32'(MAX_WIDTH)) begin
      weff32 = 32'(MAX_WIDTH);
    end
    weff = weff32[CW:0];
    heff = (cfg.image_height < 16'd2) ? 16'd2 : cfg.image_height;
  end

  assign in_full = (state_r != ST_IDLE);
  assign accept  = in_push & ~in_full;

  always_comb begin
    c_s = in_data.start_of_frame ? '0 : col_r;
    r_s = in_data.start_of_frame ? '0 : row_r;
    if ({1'b0, c_s} >= weff) begin
      c_s = '0;
      r_s = r_s + 16'd1;
    end
    if (r_s >= heff) begin
      r_s = '0;
    end
    c_n = {1'b0, c_s} + 1'b1;
    r_n = r_s;
    if (c_n >= weff) begin
      c_n = '0;
      r_n = r_s + 16'd1;
      if (r_n >= heff) begin
        r_n = '0;
      end
    end
    ra0 = (c_s == '0) ? '0 : c_s - 1'b1;
  end

  assign d0 = Z_W'(rd0_r);
  assign d1 = Z_W'(rd1_r);
  assign d2 = Z_W'(left_r);
  assign d3 = Z_W'(cur_r);
  assign v  = {d3 != '0, d2 != '0, d1 != '0, d0 != '0};
  assign nv = 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
  assign ad03 = (d0 > d3) ? (d0 - d3) : (d3 - d0);
  assign ad12 = (d1 > d2) ? (d1 - d2) : (d2 - d1);
  assign e01 = edge_ok(d0, d1);
  assign e02 = edge_ok(d0, d2);
  assign e03 = edge_ok(d0, d3);
  assign e12 = edge_ok(d1, d2);
  assign e13 = edge_ok(d1, d3);
  assign e23 = edge_ok(d2, d3);
  assign ok  = {e02 & e12 & e01, e13 & e01 & e03, e02 & e23 & e03, e13 & e12 & e23};

  always_comb begin
    sel = 4'b0000;
    if (nv == 3'd3) begin
      if (!v[0]) begin
        sel = 4'b0001;
      end else if (!v[1]) begin
        sel = 4'b0010;
      end else if (!v[2]) begin
        sel = 4'b0100;
      end else begin
        sel = 4'b1000;
      end
    end else if (nv == 3'd4) begin
      sel = (ad03 > ad12) ? 4'b1001 : 4'b0110;
    end
  end

  assign sets    = ((prow_r != '0) && (pcol_r != '0)) ? (sel & ok) : 4'b0000;
  assign advance = (state_r == ST_CLS) && ((sets == 4'b0000) || !q_full);
  assign q_push  = (state_r == ST_CLS) && (sets != 4'b0000) && !q_full;

  always_comb begin
    q_data.d0   = d0;
    q_data.d1   = d1;
    q_data.d2   = d2;
    q_data.d3   = d3;
    q_data.col  = COL_W'(pcol_r);
    q_data.row  = prow_r;
    q_data.sets = sets;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_addr_r;
    mem_wd = '0;
    unique case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
      end
      ST_CLS: begin
        mem_we = advance && (pcol_r != '0);
        mem_wa = pcol_r - 1'b1;
        mem_wd = left_r;
      end
      ST_WR2: begin
        mem_we = 1'b1;
        mem_wa = pcol_r;
        mem_wd = cur_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (accept) begin
      rd0_r <= mem[ra0];
      rd1_r <= mem[c_s];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        if (clr_addr_r == CW'(MAX_WIDTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CLS;
        end
      end
      ST_CLS: begin
        if (advance) begin
          state_nxt = plast_r ? ST_WR2 : ST_IDLE;
        end
      end
      ST_WR2: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r   <= in_data.depth_sample[SB-1:0];
      pcol_r  <= c_s;
      prow_r  <= r_s;
      plast_r <= (c_n == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      clr_addr_r <= '0;
      col_r      <= '0;
      row_r      <= '0;
      left_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (accept) begin
        col_r <= c_n[CW-1:0];
        row_r <= r_n;
      end
      if (advance) begin
        left_r <= cur_r;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/dmt_back.sv @@
// Vertex back end: walks the selected triangles and back-projects each vertex.
`default_nettype none
module dmt_back
  import dmt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  desc_t     q_data,
  output logic      q_pop,
  output logic      o_push,
  output out_item_t o_data,
  input  logic      o_pop
);

  localparam int OW = $clog2(OUT_DEPTH);

  logic             busy_r;
  desc_t            desc_r;
  logic [3:0]       mask_r;
  logic [1:0]       pos_r;
  logic [OW:0]      occ_r;
  logic             issue;
  logic [1:0]       set_idx;
  logic [3:0]       mask_clr;
  logic [1:0]       k;
  logic             vlast;
  logic [Z_W-1:0]   vz;

  logic             s0_v_r;
  logic [Z_W-1:0]   s0_z_r;
  logic [COL_W-1:0] s0_col_r;
  logic [ROW_W-1:0] s0_row_r;
  logic             s0_last_r;

  logic [16:0]      cx16, cxc, magx;
  logic [19:0]      cy16, cyc, magy;

  logic             p1_v_r;
  logic             p1_negx_r, p1_negy_r;
  logic [16:0]      p1_magx_r;
  logic [19:0]      p1_magy_r;
  logic [13:0]      p1_ua_r;
  logic [16:0]      p1_va_r;
  logic [Z_W-1:0]   p1_z_r;
  logic             p1_last_r;

  logic             p2_v_r;
  logic             p2_negx_r, p2_negy_r;
  logic [32:0]      p2_px_r;
  logic [35:0]      p2_py_r;
  logic [37:0]      p2_tu_r;
  logic [40:0]      p2_tv_r;
  logic [Z_W-1:0]   p2_z_r;
  logic             p2_last_r;

  logic [38:0]      tu_sum;
  logic [41:0]      tv_sum;
  logic [29:0]      tu_t;
  logic [32:0]      tv_t;
  logic [16:0]      tv_d;
  logic [15:0]      tex_u, tex_v;

  logic             p3_v_r;
  logic             p3_negx_r, p3_negy_r;
  logic [40:0]      p3_pxh_r;
  logic [39:0]      p3_pxl_r;
  logic [43:0]      p3_pyh_r;
  logic [39:0]      p3_pyl_r;
  logic [15:0]      p3_tu_r, p3_tv_r;
  logic [Z_W-1:0]   p3_z_r;
  logic             p3_last_r;

  logic [57:0]      sx;
  logic [60:0]      sy;

  function automatic logic [31:0] sat32(input logic neg, input logic [36:0] mag);
    logic [31:0] r;
    if (neg) begin
      r = (mag >= 37'h0080000000) ? 32'h80000000 : (~mag[31:0] + 32'd1);
    end else begin
      r = (mag > 37'h007FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
    end
    return r;
  endfunction

  assign q_pop = !busy_r && !q_empty;
  assign issue = busy_r && (occ_r < (OW+1)'(OUT_DEPTH));

  always_comb begin
    set_idx = 2'd0;
    for (int b = 3; b >= 0; b--) begin
      if (mask_r[b]) begin
        set_idx = 2'(b);
      end
    end
  end

  assign mask_clr = mask_r & ~(4'b0001 << set_idx);
  assign k        = tri_corner(set_idx, pos_r);
  assign vlast    = (pos_r == 2'd2) && (mask_clr == 4'b0000);

  always_comb begin
    case (k)
      2'd0:    vz = desc_r.d0;
      2'd1:    vz = desc_r.d1;
      2'd2:    vz = desc_r.d2;
      default: vz = desc_r.d3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc_r <= q_data;
    end
    if (issue) begin
      s0_z_r    <= vz;
      s0_col_r  <= desc_r.col - COL_W'(1) + COL_W'(k[0]);
      s0_row_r  <= desc_r.row - ROW_W'(1) + ROW_W'(k[1]);
      s0_last_r <= vlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      mask_r <= 4'b0000;
      pos_r  <= 2'd0;
      occ_r  <= '0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        mask_r <= q_data.sets;
        pos_r  <= 2'd0;
      end else if (issue) begin
        if (pos_r == 2'd2) begin
          pos_r  <= 2'd0;
          mask_r <= mask_clr;
          if (mask_clr == 4'b0000) begin
            busy_r <= 1'b0;
          end
        end else begin
          pos_r <= pos_r + 2'd1;
        end
      end
      occ_r <= occ_r + (OW+1)'(issue) - (OW+1)'(o_pop);
    end
  end

  assign cx16 = {s0_col_r, 4'b0000};
  assign cxc  = {2'b00, cfg.center_x};
  assign magx = (cxc > cx16) ? (cxc - cx16) : (cx16 - cxc);
  assign cy16 = {s0_row_r, 4'b0000};
  assign cyc  = cfg.center_y;
  assign magy = (cyc > cy16) ? (cyc - cy16) : (cy16 - cyc);

  always_ff @(posedge clk) begin
    p1_negx_r <= cxc > cx16;
    p1_negy_r <= cyc > cy16;
    p1_magx_r <= magx;
    p1_magy_r <= magy;
    p1_ua_r   <= {s0_col_r, 1'b1};
    p1_va_r   <= {s0_row_r, 1'b1};
    p1_z_r    <= s0_z_r;
    p1_last_r <= s0_last_r;

    p2_negx_r <= p1_negx_r;
    p2_negy_r <= p1_negy_r;
    p2_px_r   <= 33'(p1_z_r) * 33'(p1_magx_r);
    p2_py_r   <= 36'(p1_z_r) * 36'(p1_magy_r);
    p2_tu_r   <= 38'(p1_ua_r) * 38'(cfg.u_step);
    p2_tv_r   <= 41'(p1_va_r) * 41'(cfg.v_step);
    p2_z_r    <= p1_z_r;
    p2_last_r <= p1_last_r;

    p3_negx_r <= p2_negx_r;
    p3_negy_r <= p2_negy_r;
    p3_pxh_r  <= 41'(p2_px_r[32:16]) * 41'(cfg.inv_focal_x);
    p3_pxl_r  <= 40'(p2_px_r[15:0]) * 40'(cfg.inv_focal_x);
    p3_pyh_r  <= 44'(p2_py_r[35:16]) * 44'(cfg.inv_focal_y);
    p3_pyl_r  <= 40'(p2_py_r[15:0]) * 40'(cfg.inv_focal_y);
    p3_tu_r   <= tex_u;
    p3_tv_r   <= tex_v;
    p3_z_r    <= p2_z_r;
    p3_last_r <= p2_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else begin
      s0_v_r <= issue;
      p1_v_r <= s0_v_r;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  assign tu_sum = {1'b0, p2_tu_r} + 39'd256;
  assign tu_t   = tu_sum[38:9];
  assign tex_u  = (tu_t > 30'd65535) ? 16'hFFFF : tu_t[15:0];
  assign tv_sum = {1'b0, p2_tv_r} + 42'd256;
  assign tv_t   = tv_sum[41:9];
  assign tv_d   = 17'h10000 - tv_t[16:0];
  assign tex_v  = (tv_t >= 33'd65536) ? 16'h0000 :
                  ((tv_d > 17'd65535) ? 16'hFFFF : tv_d[15:0]);

  assign sx = {1'b0, p3_pxh_r, 16'h0000} + {18'd0, p3_pxl_r} + 58'h0000000000800000;
  assign sy = {1'b0, p3_pyh_r, 16'h0000} + {21'd0, p3_pyl_r} + 61'h0000000000800000;

  assign o_push = p3_v_r;

  always_comb begin
    o_data.pos_x       = sat32(p3_negx_r, {3'b000, sx[57:24]});
    o_data.pos_y       = sat32(p3_negy_r, sy[60:24]);
    o_data.pos_z       = p3_z_r;
    o_data.tex_u       = p3_tu_r;
    o_data.tex_v       = p3_tv_r;
    o_data.last_vertex = p3_last_r;
  end

endmodule
`default_nettype wire

@@ rtl/dmt_checker.sv @@
// Port-level checker of the depth map triangulator and its bind statement.
`default_nettype none
module dmt_checker
  import dmt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_push,
  input logic      in_full,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_reset_full: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input taken during line store clear");

  a_one_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> in_full)
    else $error("second pixel taken before the first was classified");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind depth_map_triangulator_top dmt_checker u_dmt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
`default_nettype wire
